// ===== design/knn_pkg.sv =====
// Shared types and constants for the brute-force nearest neighbor search block.
// Used by knn_sqrt, knn_ctrl, knn_dp and brute_force_knn_search; no dependencies.
package knn_pkg;

    localparam int KNN_N_MAX    = 4096;
    localparam int KNN_F_MAX    = 64;
    localparam int KNN_K_MAX    = 64;
    localparam int VALUE_W      = 16;
    localparam int DIST_W       = 38;
    localparam int ROOT_W       = DIST_W / 2;
    localparam int INDEX_W      = 13;
    localparam int RANK_W       = 6;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD_REF = 2'd0,
        CMD_LOAD_QRY = 2'd1,
        CMD_RUN      = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEIGHBOUR_COUNT = 2'd0,
        CFG_REF_COUNT       = 2'd1,
        CFG_FEATURE_COUNT   = 2'd2,
        CFG_SQUARED_MODE    = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT,
        ST_ROOT,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [11:0]         ref_slot;
        logic [5:0]          feature_slot;
        logic signed [15:0]  coordinate_value;
    } t_knn_in;

    typedef struct packed {
        logic [12:0] neighbour_index;
        logic [37:0] neighbour_distance;
        logic [5:0]  rank_slot;
        logic        status;
        logic        last_flag;
    } t_knn_out;

    typedef struct packed {
        logic              init;
        logic              ld_ref;
        logic              ld_qry;
        logic              rd_v;
        logic              rd_last;
        logic              rd_zero;
        logic              root_start;
        logic              emit;
        logic              use_root;
        logic              emit_last;
        logic              emit_err;
        logic              shift;
        logic [RANK_W-1:0] rank;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic root_done;
    } t_dp_status;

endpackage

// ===== design/brute_force_knn_search.sv =====
// Top level of the brute-force nearest neighbor search block.
// Depends on knn_pkg, knn_ctrl and knn_dp (which holds knn_sqrt).
//
// Load transactions write one coordinate. A run transaction reads every
// coordinate of every reference point in use through the single reference
// memory port, one per cycle, and lets the distance pipeline drain; then it
// gives one result per cycle in squared mode, or one result per pass of the
// bit-serial square root unit in root mode. An invalid neighbour count gives
// one error result instead of a run. busy is high for the whole run; results
// appear on o_result for exactly one cycle with o_valid high and cannot be
// stalled by the receiver.
module brute_force_knn_search #(
    parameter int N_MAX = knn_pkg::KNN_N_MAX,
    parameter int F_MAX = knn_pkg::KNN_F_MAX,
    parameter int K_MAX = knn_pkg::KNN_K_MAX
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  knn_pkg::t_knn_in                 i_item,
    input  logic                             i_cfg_we,
    input  logic [knn_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_valid,
    output knn_pkg::t_knn_out                o_result
);
    import knn_pkg::*;

    localparam int IW = $clog2(N_MAX);
    localparam int CW = (F_MAX > 1) ? $clog2(F_MAX) : 1;

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [IW-1:0] rd_i;
    logic [CW-1:0] rd_c;

    knn_ctrl #(.N_MAX(N_MAX), .F_MAX(F_MAX), .K_MAX(K_MAX)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_item.cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_rd_i      (rd_i),
        .o_rd_c      (rd_c),
        .o_busy      (busy)
    );

    knn_dp #(.N_MAX(N_MAX), .F_MAX(F_MAX), .K_MAX(K_MAX)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .i_rd_i   (rd_i),
        .i_rd_c   (rd_c),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== design/knn_sqrt.sv =====
// Iterative floor square root, two radicand bits per cycle.
// Depends on knn_pkg for the distance and root widths.
module knn_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [knn_pkg::DIST_W-1:0]  i_radicand,
    output logic                        o_done,
    output logic [knn_pkg::ROOT_W-1:0]  o_root
);
    import knn_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [DIST_W-1:0] r_x, n_x;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    always_comb begin
        rem_sh = {r_rem, r_x[DIST_W-1 -: 2]};
        trial  = (REM_W+2)'({r_root, 2'b01});
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_x    = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_x = {r_x[DIST_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = REM_W'(rem_sh - trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(rem_sh);
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== design/knn_ctrl.sv =====
// Controller: configuration registers, scan counters and the run sequence.
// Depends on knn_pkg for the state, command and configuration types.
module knn_ctrl #(
    parameter int N_MAX = knn_pkg::KNN_N_MAX,
    parameter int F_MAX = knn_pkg::KNN_F_MAX,
    parameter int K_MAX = knn_pkg::KNN_K_MAX,
    localparam int IW = $clog2(N_MAX),
    localparam int CW = (F_MAX > 1) ? $clog2(F_MAX) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [1:0]                       i_cmd,
    input  logic                             i_cfg_we,
    input  logic [knn_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  knn_pkg::t_dp_status              i_status,
    output knn_pkg::t_dp_cmd                 o_cmd,
    output logic [IW-1:0]                    o_rd_i,
    output logic [CW-1:0]                    o_rd_c,
    output logic                             o_busy
);
    import knn_pkg::*;

    t_state        r_state, n_state;
    logic [6:0]    r_k;
    logic [12:0]   r_nref_cfg;
    logic [6:0]    r_nfeat_cfg;
    logic          r_sq_mode;
    logic [IW-1:0] r_i, n_i, r_nref_m1, n_nref_m1;
    logic [CW-1:0] r_c, n_c, r_nfeat_m1, n_nfeat_m1;
    logic          r_zero, n_zero;
    logic [RANK_W-1:0] r_rank, n_rank, r_k_m1, n_k_m1;
    int            nref_eff;
    int            nfeat_eff;
    logic          bad_k;
    logic          accept;

    always_comb begin
        nref_eff  = (int'(r_nref_cfg) > N_MAX) ? N_MAX : int'(r_nref_cfg);
        nfeat_eff = (int'(r_nfeat_cfg) > F_MAX) ? F_MAX : int'(r_nfeat_cfg);
        bad_k     = (r_k == 7'd0) || (int'(r_k) > K_MAX) || (int'(r_k) > nref_eff);
    end

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_c        = r_c;
        n_nref_m1  = r_nref_m1;
        n_nfeat_m1 = r_nfeat_m1;
        n_zero     = r_zero;
        n_rank     = r_rank;
        n_k_m1     = r_k_m1;
        o_cmd      = '0;
        o_cmd.rank = r_rank;
        o_cmd.use_root  = !r_sq_mode;
        o_cmd.emit_last = (r_rank == r_k_m1);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_LOAD_REF: o_cmd.ld_ref = 1'b1;
                        CMD_LOAD_QRY: o_cmd.ld_qry = 1'b1;
                        CMD_RUN: begin
                            if (bad_k) begin
                                n_state = ST_ERR;
                            end else begin
                                o_cmd.init = 1'b1;
                                n_state    = ST_RUN;
                                n_i        = '0;
                                n_c        = '0;
                                n_rank     = '0;
                                n_k_m1     = RANK_W'(int'(r_k) - 1);
                                n_nref_m1  = IW'(nref_eff - 1);
                                n_zero     = (nfeat_eff == 0);
                                n_nfeat_m1 = (nfeat_eff == 0) ? '0 : CW'(nfeat_eff - 1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.rd_v    = 1'b1;
                o_cmd.rd_zero = r_zero;
                o_cmd.rd_last = (r_c == r_nfeat_m1);
                if (r_c == r_nfeat_m1) begin
                    n_c = '0;
                    if (r_i == r_nref_m1) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_sq_mode) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.shift = 1'b1;
                    n_rank      = r_rank + 1'b1;
                    if (r_rank == r_k_m1) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_cmd.root_start = 1'b1;
                    n_state          = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (i_status.root_done) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.shift = 1'b1;
                    n_rank      = r_rank + 1'b1;
                    n_state     = (r_rank == r_k_m1) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_ERR: begin
                o_cmd.emit_err = 1'b1;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= 7'd1;
            r_nref_cfg  <= 13'd1;
            r_nfeat_cfg <= 7'd1;
            r_sq_mode   <= 1'b1;
            r_i         <= '0;
            r_c         <= '0;
            r_rank      <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_c     <= n_c;
            r_rank  <= n_rank;
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_NEIGHBOUR_COUNT: r_k         <= i_cfg_data[6:0];
                    CFG_REF_COUNT:       r_nref_cfg  <= i_cfg_data;
                    CFG_FEATURE_COUNT:   r_nfeat_cfg <= i_cfg_data[6:0];
                    CFG_SQUARED_MODE:    r_sq_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        r_nref_m1  <= n_nref_m1;
        r_nfeat_m1 <= n_nfeat_m1;
        r_zero     <= n_zero;
        r_k_m1     <= n_k_m1;
    end

    assign o_rd_i = r_i;
    assign o_rd_c = r_c;
    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== design/knn_dp.sv =====
// Datapath: coordinate memories, distance pipeline, sorted insertion cells,
// root unit and the result register. Depends on knn_pkg and knn_sqrt.
module knn_dp #(
    parameter int N_MAX = knn_pkg::KNN_N_MAX,
    parameter int F_MAX = knn_pkg::KNN_F_MAX,
    parameter int K_MAX = knn_pkg::KNN_K_MAX,
    localparam int IW = $clog2(N_MAX),
    localparam int CW = (F_MAX > 1) ? $clog2(F_MAX) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  knn_pkg::t_dp_cmd       i_cmd,
    input  knn_pkg::t_knn_in       i_item,
    input  logic [IW-1:0]          i_rd_i,
    input  logic [CW-1:0]          i_rd_c,
    output knn_pkg::t_dp_status    o_status,
    output logic                   o_valid,
    output knn_pkg::t_knn_out      o_result
);
    import knn_pkg::*;

    localparam int DEPTH = N_MAX * F_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIW   = (IW > INDEX_W) ? IW : INDEX_W;
    localparam logic [SIW-1:0] IDX_SENTINEL = SIW'({INDEX_W{1'b1}});
    localparam int SQ_W  = 2 * (VALUE_W + 1);

    logic [VALUE_W-1:0] mem_ref [DEPTH];
    logic [VALUE_W-1:0] mem_qry [F_MAX];

    logic [AW-1:0] wr_addr, rd_addr;
    logic          ref_ok, qry_ok;

    logic signed [VALUE_W-1:0] r_ref_q, r_qry_q;
    logic r_s1_v, r_s1_last, r_s1_zero;
    logic [IW-1:0] r_s1_idx;
    logic signed [VALUE_W:0]   diff;
    logic signed [SQ_W-1:0]    prod;
    logic [SQ_W-1:0] r_sq;
    logic r_s2_v, r_s2_last;
    logic [IW-1:0] r_s2_idx;
    logic [DIST_W-1:0] r_acc, acc_sat;
    logic [DIST_W:0]   acc_sum;
    logic r_ins_v;
    logic [DIST_W-1:0] r_ins_d;
    logic [SIW-1:0]    r_ins_idx;

    logic [DIST_W-1:0] r_cd [K_MAX];
    logic [SIW-1:0]    r_ci [K_MAX];
    logic [K_MAX-1:0]  less;

    logic              root_done;
    logic [ROOT_W-1:0] root;
    logic              r_valid;
    t_knn_out          r_out;

    always_comb begin
        ref_ok  = (int'(i_item.ref_slot) < N_MAX) && (int'(i_item.feature_slot) < F_MAX);
        qry_ok  = (int'(i_item.feature_slot) < F_MAX);
        wr_addr = AW'(int'(i_item.ref_slot) * F_MAX + int'(i_item.feature_slot));
        rd_addr = AW'(int'(i_rd_i) * F_MAX + int'(i_rd_c));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_ref && ref_ok) begin
            mem_ref[wr_addr] <= i_item.coordinate_value;
        end
        r_ref_q <= mem_ref[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_qry && qry_ok) begin
            mem_qry[CW'(i_item.feature_slot)] <= i_item.coordinate_value;
        end
        r_qry_q <= mem_qry[i_rd_c];
    end

    always_comb begin
        diff    = (VALUE_W+1)'(r_ref_q) - (VALUE_W+1)'(r_qry_q);
        prod    = diff * diff;
        acc_sum = (DIST_W+1)'(r_acc) + (DIST_W+1)'(r_sq);
        acc_sat = acc_sum[DIST_W] ? DIST_ALL_ONES : acc_sum[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_ins_v <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_s1_v  <= i_cmd.rd_v;
            r_s2_v  <= r_s1_v;
            r_ins_v <= r_s2_v && r_s2_last;
            if (r_s2_v) begin
                r_acc <= r_s2_last ? '0 : acc_sat;
            end
        end
        r_s1_last <= i_cmd.rd_last;
        r_s1_zero <= i_cmd.rd_zero;
        r_s1_idx  <= i_rd_i;
        r_sq      <= r_s1_zero ? '0 : SQ_W'(prod);
        r_s2_last <= r_s1_last;
        r_s2_idx  <= r_s1_idx;
        r_ins_d   <= acc_sat;
        r_ins_idx <= SIW'(r_s2_idx);
    end

    // Each cell compares the new key (distance, then index on a tie) against its
    // own entry; a smaller key pushes the list down by one from the first cell where it wins.
    genvar j;
    generate
        for (j = 0; j < K_MAX; j++) begin : g_cell
            assign less[j] = (r_ins_d < r_cd[j]) ||
                             ((r_ins_d == r_cd[j]) && (r_ins_idx < r_ci[j]));
            always_ff @(posedge i_clk) begin
                if (i_cmd.init) begin
                    r_cd[j] <= DIST_ALL_ONES;
                    r_ci[j] <= IDX_SENTINEL;
                end else if (r_ins_v) begin
                    if (less[j]) begin
                        if (j > 0 && less[(j > 0) ? j - 1 : 0]) begin
                            r_cd[j] <= r_cd[(j > 0) ? j - 1 : 0];
                            r_ci[j] <= r_ci[(j > 0) ? j - 1 : 0];
                        end else begin
                            r_cd[j] <= r_ins_d;
                            r_ci[j] <= r_ins_idx;
                        end
                    end
                end else if (i_cmd.shift) begin
                    if (j == K_MAX - 1) begin
                        r_cd[j] <= DIST_ALL_ONES;
                        r_ci[j] <= IDX_SENTINEL;
                    end else begin
                        r_cd[j] <= r_cd[(j < K_MAX - 1) ? j + 1 : j];
                        r_ci[j] <= r_ci[(j < K_MAX - 1) ? j + 1 : j];
                    end
                end
            end
        end
    endgenerate

    knn_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_start),
        .i_radicand (r_cd[0]),
        .o_done     (root_done),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit || i_cmd.emit_err;
        end
        if (i_cmd.emit_err) begin
            r_out.neighbour_index    <= '0;
            r_out.neighbour_distance <= '0;
            r_out.rank_slot          <= '0;
            r_out.status             <= 1'b1;
            r_out.last_flag          <= 1'b1;
        end else begin
            r_out.neighbour_index    <= INDEX_W'(r_ci[0] + 1'b1);
            r_out.neighbour_distance <= i_cmd.use_root ? DIST_W'(root) : r_cd[0];
            r_out.rank_slot          <= i_cmd.rank;
            r_out.status             <= 1'b0;
            r_out.last_flag          <= i_cmd.emit_last;
        end
    end

    assign o_status.pipe_busy = r_s1_v || r_s2_v || r_ins_v;
    assign o_status.root_done = root_done;
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule
